### sv/matrix_chain_order_assert.svh
// Assertion macros for the matrix chain order block.
// Used by the checker; needs a clk and an active-low rst_n in scope.
`ifndef MATRIX_CHAIN_ORDER_ASSERT_SVH
`define MATRIX_CHAIN_ORDER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MCO_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MCO_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/mco_pkg.sv
// Package for the matrix chain order block: widths, defaults, token codes
// and the sequencer state type. No dependencies.
package mco_pkg;

    localparam int MAX_MATRICES_DEF = 16;
    localparam int DIM_BITS_DEF     = 10;
    localparam int IN_DIM_W         = 10;
    localparam int COST_W           = 40;
    localparam int NUM_W            = 5;
    localparam int KIND_W           = 2;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    typedef enum logic [KIND_W-1:0] {
        TOK_MATRIX = 2'd0,
        TOK_OPEN   = 2'd1,
        TOK_CLOSE  = 2'd2
    } tok_kind_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DIAG,
        S_ISET,
        S_ILAT,
        S_RD,
        S_MUL1,
        S_MUL2,
        S_CMP,
        W_INIT,
        W_INIT2,
        W_POP,
        W_DEC,
        W_SPL,
        W_SPW,
        W_P1,
        W_P2,
        W_P3
    } mco_state_t;

endpackage

### sv/matrix_chain_order.sv
// Matrix chain order: loads a chain, fills cost and split tables with one shared
// multiply/add/compare unit, then walks the split table to emit tokens.
// After the last item the block fills the diagonal, then each longer interval in turn,
// then starts the walk and emits one token for each stack entry that it pops. Items
// are loaded one per cycle while the block is idle.
// Reset (asynchronous, active low) clears the sequencer, chain length and flags.
module matrix_chain_order
    import mco_pkg::*;
#(
    parameter int MAX_MATRICES = MAX_MATRICES_DEF,
    parameter int DIM_BITS     = DIM_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [IN_DIM_W-1:0] rows,
    input  logic [IN_DIM_W-1:0] cols,
    input  logic                last,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [KIND_W-1:0]   token_kind,
    output logic [NUM_W-1:0]    matrix_number,
    output logic [COST_W-1:0]   min_cost,
    output logic                overflow,
    output logic                end_of_run
);

    // Index, count and address widths all follow from the chain capacity.
    localparam int IW  = (MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1;
    localparam int CW  = $clog2(MAX_MATRICES + 1);
    localparam int AW  = 2 * IW;
    localparam int SD  = 2 * MAX_MATRICES;
    localparam int SAW = $clog2(SD);
    localparam int SPW = $clog2(SD + 1);
    localparam int P1W = 2 * DIM_BITS;
    localparam int P2W = 3 * DIM_BITS;
    localparam int XW  = P2W + COST_W;

    // A walk stack entry is either a pending interval or a pending close bracket.
    typedef struct packed {
        logic          is_close;
        logic [IW-1:0] b;
        logic [IW-1:0] e;
    } stk_entry_t;

    // Storage. All of these are undefined until written in the current run.
    logic [DIM_BITS-1:0] row_mem   [0:MAX_MATRICES-1];
    logic [DIM_BITS-1:0] col_mem   [0:MAX_MATRICES-1];
    logic [COST_W-1:0]   cost_mem  [0:(1<<AW)-1];
    logic [IW-1:0]       split_mem [0:(1<<AW)-1];
    stk_entry_t          stk_mem   [0:SD-1];

    mco_state_t state_reg, state_next;

    logic [CW-1:0]       chain_len_reg, chain_len_next;
    logic                ovf_reg, ovf_next;
    logic [CW-1:0]       n_reg, n_next;
    logic [CW-1:0]       len_reg, len_next;
    logic [IW-1:0]       i_reg, i_next;
    logic [IW-1:0]       k_reg, k_next;
    logic [DIM_BITS-1:0] ri_reg, ri_next;
    logic [DIM_BITS-1:0] cj_reg, cj_next;
    logic [P1W-1:0]      prod1_reg, prod1_next;
    logic [P2W-1:0]      prod2_reg, prod2_next;
    logic [COST_W-1:0]   sum_reg, sum_next;
    logic [COST_W-1:0]   best_reg, best_next;
    logic [IW-1:0]       bsplit_reg, bsplit_next;
    logic [SPW-1:0]      sp_reg, sp_next;
    logic [IW-1:0]       b_reg, b_next;
    logic [IW-1:0]       e_reg, e_next;
    logic [IW-1:0]       s_reg, s_next;
    logic [COST_W-1:0]   total_cost_reg, total_cost_next;
    logic [NUM_W-1:0]    emit_cnt_reg, emit_cnt_next;

    // Output register.
    logic                out_valid_reg, out_valid_next;
    tok_kind_t           kind_reg, kind_next;
    logic [NUM_W-1:0]    num_reg, num_next;
    logic [COST_W-1:0]   cost_out_reg, cost_out_next;
    logic                ovf_out_reg, ovf_out_next;
    logic                end_reg, end_next;

    // Registered read data.
    logic [DIM_BITS-1:0] row_rd_reg;
    logic [DIM_BITS-1:0] col_rd_reg;
    logic [COST_W-1:0]   cost_rd_a_reg;
    logic [COST_W-1:0]   cost_rd_b_reg;
    logic [IW-1:0]       split_rd_reg;
    stk_entry_t          stk_rd_reg;

    // Memory ports.
    logic                dim_we;
    logic [IW-1:0]       dim_waddr;
    logic [IW-1:0]       col_raddr;
    logic                cost_we;
    logic [AW-1:0]       cost_waddr;
    logic [COST_W-1:0]   cost_wdata;
    logic [AW-1:0]       cost_raddr_a;
    logic [AW-1:0]       cost_raddr_b;
    logic                split_we;
    logic [AW-1:0]       split_addr;
    logic                stk_we;
    stk_entry_t          stk_wdata;

    // Current interval end j = i + len - 1, with a spare bit for the row check.
    logic [CW:0]         j_sum;
    logic [IW-1:0]       j_idx;
    logic                row_done;
    logic                k_last;

    // Shared cost unit: saturate the product, add it to the split sum, compare.
    logic [XW-1:0]       prod_ext;
    logic [COST_W-1:0]   prod_sat;
    logic [COST_W:0]     cand_sum;
    logic [COST_W-1:0]   cand;
    logic                better;
    logic [COST_W:0]     pair_sum;

    logic                can_load;
    logic                leaf;
    logic                is_final;
    logic [IW-1:0]       s_fix;

    assign j_sum    = (CW+1)'(i_reg) + (CW+1)'(len_reg) - (CW+1)'(1);
    assign j_idx    = j_sum[IW-1:0];
    assign row_done = (j_sum == ((CW+1)'(n_reg) - (CW+1)'(1)));
    assign k_last   = (((IW+1)'(k_reg) + (IW+1)'(1)) == (IW+1)'(j_idx));

    assign prod_ext = XW'(prod2_reg);
    assign prod_sat = (prod_ext > XW'(COST_MAX)) ? COST_MAX : prod_ext[COST_W-1:0];
    assign cand_sum = {1'b0, sum_reg} + {1'b0, prod_sat};
    assign cand     = cand_sum[COST_W] ? COST_MAX : cand_sum[COST_W-1:0];
    assign better   = (cand < best_reg);
    assign pair_sum = {1'b0, cost_rd_a_reg} + {1'b0, cost_rd_b_reg};

    assign can_load = !out_valid_reg || !out_stall;
    assign leaf     = !stk_rd_reg.is_close && (stk_rd_reg.b == stk_rd_reg.e);
    assign is_final = (sp_reg == SPW'(1)) && (stk_rd_reg.is_close || leaf);
    assign s_fix    = ((split_rd_reg < b_reg) || (split_rd_reg >= e_reg)) ? b_reg
                                                                          : split_rd_reg;

    assign dim_waddr    = chain_len_reg[IW-1:0];
    assign col_raddr    = (state_reg == S_ISET) ? j_idx : k_reg;
    assign cost_raddr_a = (state_reg == W_INIT) ? {{IW{1'b0}}, IW'(n_reg - CW'(1))}
                                                : {i_reg, k_reg};
    assign cost_raddr_b = {IW'((IW+1)'(k_reg) + (IW+1)'(1)), j_idx};
    assign split_addr   = (state_reg == S_CMP) ? {i_reg, j_idx} : {b_reg, e_reg};

    // The block takes items only while it is not computing or walking.
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        chain_len_next  = chain_len_reg;
        ovf_next        = ovf_reg;
        n_next          = n_reg;
        len_next        = len_reg;
        i_next          = i_reg;
        k_next          = k_reg;
        ri_next         = ri_reg;
        cj_next         = cj_reg;
        prod1_next      = prod1_reg;
        prod2_next      = prod2_reg;
        sum_next        = sum_reg;
        best_next       = best_reg;
        bsplit_next     = bsplit_reg;
        sp_next         = sp_reg;
        b_next          = b_reg;
        e_next          = e_reg;
        s_next          = s_reg;
        total_cost_next = total_cost_reg;
        emit_cnt_next   = emit_cnt_reg;
        out_valid_next  = out_valid_reg && out_stall;
        kind_next       = kind_reg;
        num_next        = num_reg;
        cost_out_next   = cost_out_reg;
        ovf_out_next    = ovf_out_reg;
        end_next        = end_reg;
        dim_we          = 1'b0;
        cost_we         = 1'b0;
        cost_waddr      = {i_reg, i_reg};
        cost_wdata      = '0;
        split_we        = 1'b0;
        stk_we          = 1'b0;
        stk_wdata       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (chain_len_reg < CW'(MAX_MATRICES))
                    begin
                        dim_we         = 1'b1;
                        chain_len_next = chain_len_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last)
                    begin
                        n_next     = chain_len_next;
                        i_next     = '0;
                        state_next = S_DIAG;
                    end
                end
            end
            S_DIAG:
            begin
                cost_we    = 1'b1;
                cost_waddr = {i_reg, i_reg};
                cost_wdata = '0;
                if ((CW'(i_reg) + CW'(1)) == n_reg)
                begin
                    i_next     = '0;
                    len_next   = CW'(2);
                    state_next = (n_reg == CW'(1)) ? W_INIT : S_ISET;
                end
                else
                begin
                    i_next = i_reg + IW'(1);
                end
            end
            S_ISET:
            begin
                state_next = S_ILAT;
            end
            S_ILAT:
            begin
                ri_next     = row_rd_reg;
                cj_next     = col_rd_reg;
                best_next   = COST_MAX;
                bsplit_next = i_reg;
                k_next      = i_reg;
                state_next  = S_RD;
            end
            S_RD:
            begin
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                prod1_next = P1W'(ri_reg) * P1W'(col_rd_reg);
                sum_next   = pair_sum[COST_W] ? COST_MAX : pair_sum[COST_W-1:0];
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                prod2_next = P2W'(prod1_reg) * P2W'(cj_reg);
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (better)
                begin
                    best_next   = cand;
                    bsplit_next = k_reg;
                end
                if (k_last)
                begin
                    cost_we    = 1'b1;
                    cost_waddr = {i_reg, j_idx};
                    cost_wdata = best_next;
                    split_we   = 1'b1;
                    if (row_done)
                    begin
                        i_next = '0;
                        if (len_reg == n_reg)
                        begin
                            state_next = W_INIT;
                        end
                        else
                        begin
                            len_next   = len_reg + CW'(1);
                            state_next = S_ISET;
                        end
                    end
                    else
                    begin
                        i_next     = i_reg + IW'(1);
                        state_next = S_ISET;
                    end
                end
                else
                begin
                    k_next     = k_reg + IW'(1);
                    state_next = S_RD;
                end
            end
            W_INIT:
            begin
                state_next = W_INIT2;
            end
            W_INIT2:
            begin
                total_cost_next = cost_rd_a_reg;
                emit_cnt_next   = NUM_W'(1);
                stk_we          = 1'b1;
                stk_wdata       = '{is_close: 1'b0, b: '0, e: IW'(n_reg - CW'(1))};
                sp_next         = sp_reg + SPW'(1);
                state_next      = W_POP;
            end
            W_POP:
            begin
                state_next = W_DEC;
            end
            W_DEC:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    cost_out_next  = total_cost_reg;
                    ovf_out_next   = ovf_reg;
                    end_next       = is_final;
                    sp_next        = sp_reg - SPW'(1);
                    if (stk_rd_reg.is_close)
                    begin
                        kind_next = TOK_CLOSE;
                        num_next  = '0;
                    end
                    else if (leaf)
                    begin
                        kind_next     = TOK_MATRIX;
                        num_next      = emit_cnt_reg;
                        emit_cnt_next = emit_cnt_reg + NUM_W'(1);
                    end
                    else
                    begin
                        kind_next = TOK_OPEN;
                        num_next  = '0;
                    end
                    b_next = stk_rd_reg.b;
                    e_next = stk_rd_reg.e;
                    s_next = stk_rd_reg.b;
                    if (stk_rd_reg.is_close || leaf)
                    begin
                        if (is_final)
                        begin
                            chain_len_next = '0;
                            ovf_next       = 1'b0;
                            emit_cnt_next  = NUM_W'(1);
                            state_next     = S_IDLE;
                        end
                        else
                        begin
                            state_next = W_POP;
                        end
                    end
                    else if ((stk_rd_reg.e - stk_rd_reg.b) == IW'(1))
                    begin
                        state_next = W_P1;
                    end
                    else
                    begin
                        state_next = W_SPL;
                    end
                end
            end
            W_SPL:
            begin
                state_next = W_SPW;
            end
            W_SPW:
            begin
                s_next     = s_fix;
                state_next = W_P1;
            end
            W_P1:
            begin
                stk_we     = 1'b1;
                stk_wdata  = '{is_close: 1'b1, b: '0, e: '0};
                sp_next    = sp_reg + SPW'(1);
                state_next = W_P2;
            end
            W_P2:
            begin
                stk_we     = 1'b1;
                stk_wdata  = '{is_close: 1'b0, b: s_reg + IW'(1), e: e_reg};
                sp_next    = sp_reg + SPW'(1);
                state_next = W_P3;
            end
            W_P3:
            begin
                stk_we     = 1'b1;
                stk_wdata  = '{is_close: 1'b0, b: b_reg, e: s_reg};
                sp_next    = sp_reg + SPW'(1);
                state_next = W_POP;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            chain_len_reg <= '0;
            ovf_reg       <= 1'b0;
            sp_reg        <= '0;
            emit_cnt_reg  <= NUM_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chain_len_reg <= chain_len_next;
            ovf_reg       <= ovf_next;
            sp_reg        <= sp_next;
            emit_cnt_reg  <= emit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg          <= n_next;
        len_reg        <= len_next;
        i_reg          <= i_next;
        k_reg          <= k_next;
        ri_reg         <= ri_next;
        cj_reg         <= cj_next;
        prod1_reg      <= prod1_next;
        prod2_reg      <= prod2_next;
        sum_reg        <= sum_next;
        best_reg       <= best_next;
        bsplit_reg     <= bsplit_next;
        b_reg          <= b_next;
        e_reg          <= e_next;
        s_reg          <= s_next;
        total_cost_reg <= total_cost_next;
        kind_reg       <= kind_next;
        num_reg        <= num_next;
        cost_out_reg   <= cost_out_next;
        ovf_out_reg    <= ovf_out_next;
        end_reg        <= end_next;
    end

    // Dimension stores: one write port, one read port each.
    always_ff @(posedge clk)
    begin
        if (dim_we)
        begin
            row_mem[dim_waddr] <= DIM_BITS'(rows);
            col_mem[dim_waddr] <= DIM_BITS'(cols);
        end
        row_rd_reg <= row_mem[i_reg];
        col_rd_reg <= col_mem[col_raddr];
    end

    // Cost table: one write port, two read ports for the two halves of a split.
    always_ff @(posedge clk)
    begin
        if (cost_we)
        begin
            cost_mem[cost_waddr] <= cost_wdata;
        end
        cost_rd_a_reg <= cost_mem[cost_raddr_a];
        cost_rd_b_reg <= cost_mem[cost_raddr_b];
    end

    // Split table: a single port, written by the fill and read by the walk.
    always_ff @(posedge clk)
    begin
        if (split_we)
        begin
            split_mem[split_addr] <= bsplit_next;
        end
        split_rd_reg <= split_mem[split_addr];
    end

    // Walk stack: push at the stack pointer, read the top entry.
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[sp_reg[SAW-1:0]] <= stk_wdata;
        end
        stk_rd_reg <= stk_mem[SAW'(sp_reg - SPW'(1))];
    end

    assign out_valid     = out_valid_reg;
    assign token_kind    = kind_reg;
    assign matrix_number = num_reg;
    assign min_cost      = cost_out_reg;
    assign overflow      = ovf_out_reg;
    assign end_of_run    = end_reg;

endmodule

### sv/mco_checker.sv
// Port-level checker for the matrix chain order block, bound to its top level.
// Depends on mco_pkg and the assertion macro header.
`include "matrix_chain_order_assert.svh"

module mco_checker
    import mco_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [KIND_W-1:0] token_kind,
    input logic [NUM_W-1:0]  matrix_number,
    input logic [COST_W-1:0] min_cost,
    input logic              end_of_run
);

    // A stalled transaction keeps its token and cost.
    `MCO_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(token_kind) && $stable(min_cost), "stalled output token changed")

    // Brackets carry no matrix number.
    `MCO_ASSERT_NOW(a_bracket_num, out_valid && (token_kind != TOK_MATRIX), matrix_number == '0, "bracket token with a matrix number")

    // While a run is still being emitted, no new item is taken.
    `MCO_ASSERT_NOW(a_busy_walk, out_valid && !end_of_run, in_stall, "input taken in the middle of a run")

    // A run never ends on an open bracket.
    `MCO_ASSERT_NOW(a_end_kind, out_valid && end_of_run, token_kind != TOK_OPEN, "run ended on an open bracket")

endmodule

bind matrix_chain_order mco_checker u_mco_checker (.*);

### tb/tb_matrix_chain_order.sv
// Testbench for matrix_chain_order: directed and random matrix chains, with
// an internal predictor of the token stream. Depends on mco_pkg and the RTL.
`timescale 1ns / 100ps

module tb_matrix_chain_order;
    import mco_pkg::*;

    localparam int NMAX = MAX_MATRICES_DEF;

    // One expected token of the parenthesization.
    typedef struct {
        tok_kind_t         kind;
        logic [NUM_W-1:0]  num;
        logic [COST_W-1:0] cost;
        logic              ovf;
        logic              eor;
    } token_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [IN_DIM_W-1:0] rows = '0;
    logic [IN_DIM_W-1:0] cols = '0;
    logic last = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [KIND_W-1:0] token_kind;
    logic [NUM_W-1:0] matrix_number;
    logic [COST_W-1:0] min_cost;
    logic overflow;
    logic end_of_run;

    always #5 clk = ~clk;

    matrix_chain_order u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .rows(rows), .cols(cols), .last(last),
        .out_valid(out_valid), .out_stall(out_stall),
        .token_kind(token_kind), .matrix_number(matrix_number),
        .min_cost(min_cost), .overflow(overflow), .end_of_run(end_of_run)
    );

    // Predictor state: the chain loaded so far and the interval tables.
    logic [IN_DIM_W-1:0] chain_rows[NMAX];
    logic [IN_DIM_W-1:0] chain_cols[NMAX];
    logic [COST_W-1:0]   best_cost[NMAX][NMAX];
    int                  best_split[NMAX][NMAX];
    int                  loaded;
    logic                dropped;
    int                  leaf_no;
    token_t              pending_tokens[$];
    token_t              walk_tokens[$];

    int  mismatches = 0;
    int  items_sent = 0;
    int  chains_done = 0;
    int  tokens_seen = 0;
    int  longest_chain = 0;
    bit  quiet_tx = 1'b0;
    bit  quiet_rx = 1'b0;
    int  stall_left = 0;

    function automatic logic [COST_W-1:0] sat_sum(logic [63:0] a, logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s > COST_MAX) ? COST_MAX : s[COST_W-1:0];
    endfunction

    // Interval dynamic program; the first (smallest) split wins on ties.
    function automatic void fill_intervals(int n);
        logic [63:0] prod;
        logic [COST_W-1:0] cand;
        logic [COST_W-1:0] best;
        int bsplit;
        for (int i = 0; i < n; i++)
        begin
            best_cost[i][i] = '0;
            best_split[i][i] = i;
        end
        for (int len = 2; len <= n; len++)
        begin
            for (int i = 0; i + len <= n; i++)
            begin
                int j;
                j = i + len - 1;
                best = COST_MAX;
                bsplit = i;
                for (int k = i; k < j; k++)
                begin
                    prod = 64'(chain_rows[i]) * 64'(chain_cols[k]) * 64'(chain_cols[j]);
                    if (prod > COST_MAX)
                        prod = COST_MAX;
                    cand = sat_sum(best_cost[i][k], best_cost[k+1][j]);
                    cand = sat_sum(cand, prod);
                    if (cand < best)
                    begin
                        best = cand;
                        bsplit = k;
                    end
                end
                best_cost[i][j] = best;
                best_split[i][j] = bsplit;
            end
        end
    endfunction

    function automatic void add_token(tok_kind_t kind, int num, logic [COST_W-1:0] cost);
        token_t t;
        t.kind = kind;
        t.num  = num[NUM_W-1:0];
        t.cost = cost;
        t.ovf  = dropped;
        t.eor  = 1'b0;
        walk_tokens.push_back(t);
    endfunction

    function automatic void add_leaf(logic [COST_W-1:0] cost);
        add_token(TOK_MATRIX, leaf_no, cost);
        leaf_no++;
    endfunction

    // Recursive walk of the split table; pairs are bracketed as well.
    function automatic void walk_interval(int b, int e, logic [COST_W-1:0] cost);
        int s;
        if (b == e)
        begin
            add_leaf(cost);
            return;
        end
        add_token(TOK_OPEN, 0, cost);
        if (e - b == 1)
        begin
            add_leaf(cost);
            add_leaf(cost);
        end
        else
        begin
            s = best_split[b][e];
            if (s < b || s >= e)
                s = b;
            walk_interval(b, s, cost);
            walk_interval(s + 1, e, cost);
        end
        add_token(TOK_CLOSE, 0, cost);
    endfunction

    // Called once per accepted input transaction.
    function automatic void predict_tokens(logic [IN_DIM_W-1:0] r, logic [IN_DIM_W-1:0] c,
                                           logic l);
        token_t t;
        if (loaded < NMAX)
        begin
            chain_rows[loaded] = r;
            chain_cols[loaded] = c;
            loaded++;
        end
        else
            dropped = 1'b1;
        if (!l)
            return;
        fill_intervals(loaded);
        leaf_no = 1;
        walk_tokens.delete();
        walk_interval(0, loaded - 1, best_cost[0][loaded-1]);
        t = walk_tokens.pop_back();
        t.eor = 1'b1;
        walk_tokens.push_back(t);
        foreach (walk_tokens[i])
            pending_tokens.push_back(walk_tokens[i]);
        if (loaded > longest_chain)
            longest_chain = loaded;
        chains_done++;
        loaded = 0;
        dropped = 1'b0;
    endfunction

    // Output side: random stall per token, and each accepted token is checked
    // against the oldest pending expectation.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                tokens_seen++;
                if (pending_tokens.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected token kind=%0d num=%0d cost=%0d",
                                 token_kind, matrix_number, min_cost);
                end
                else
                begin
                    token_t e;
                    e = pending_tokens.pop_front();
                    if (token_kind !== e.kind || matrix_number !== e.num ||
                        min_cost !== e.cost || overflow !== e.ovf ||
                        end_of_run !== e.eor)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: token %0d exp kind=%0d num=%0d cost=%0d ovf=%0b eor=%0b, got kind=%0d num=%0d cost=%0d ovf=%0b eor=%0b",
                                     tokens_seen, e.kind, e.num, e.cost, e.ovf, e.eor,
                                     token_kind, matrix_number, min_cost, overflow,
                                     end_of_run);
                    end
                end
                stall_left = quiet_rx ? 0 : $urandom_range(0, 17);
                out_stall <= (stall_left != 0);
            end
            else if (out_stall)
            begin
                if (stall_left <= 1)
                begin
                    stall_left = 0;
                    out_stall <= 1'b0;
                end
                else
                    stall_left--;
            end
        end
    end

    // Sends one matrix; valid stays high when no gap is drawn.
    task automatic send_matrix(int r, int c, bit l);
        int gap;
        gap = quiet_tx ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rows <= r[IN_DIM_W-1:0];
        cols <= c[IN_DIM_W-1:0];
        last <= l;
        do
            @(posedge clk);
        while (in_stall);
        predict_tokens(r[IN_DIM_W-1:0], c[IN_DIM_W-1:0], l);
        items_sent++;
    endtask

    // Holds the input until every expected token has been delivered.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_tokens.size() != 0)
            @(posedge clk);
    endtask

    // A chain of n matrices whose dimensions link up (rows follow the previous cols).
    task automatic send_linked_chain(int n, int dmax);
        int r;
        int c;
        r = $urandom_range(0, dmax);
        for (int i = 0; i < n; i++)
        begin
            c = $urandom_range(0, dmax);
            send_matrix(r, c, i == n - 1);
            r = c;
        end
    endtask

    task automatic test_lone_and_pair();
        send_matrix(7, 9, 1'b1);
        send_matrix(1023, 1023, 1'b1);
        send_matrix(0, 0, 1'b1);
        send_matrix(1023, 0, 1'b0);
        send_matrix(0, 1023, 1'b1);
        send_matrix(1023, 1023, 1'b0);
        send_matrix(1023, 1023, 1'b1);
        wait_drained();
    endtask

    // Equal dimensions make every split cost the same, so the smallest must win.
    task automatic test_ties_and_extremes();
        for (int i = 0; i < 5; i++)
            send_matrix(3, 3, i == 4);
        for (int i = 0; i < 4; i++)
            send_matrix(1023, 1023, i == 3);
        wait_drained();
    endtask

    // A full chain at capacity, then a chain with drops whose dropped item carries last.
    task automatic test_capacity();
        quiet_tx = 1'b1;
        quiet_rx = 1'b1;
        send_linked_chain(NMAX, 1023);
        for (int i = 0; i < NMAX + 2; i++)
            send_matrix($urandom_range(0, 1023), $urandom_range(0, 1023), i == NMAX + 1);
        quiet_tx = 1'b0;
        quiet_rx = 1'b0;
        wait_drained();
    endtask

    // Mostly linked chains of random length; some overflow, some unlinked noise.
    task automatic test_random_chains();
        int pick;
        int n;
        int dmax;
        while (items_sent < 410)
        begin
            pick = $urandom_range(0, 99);
            quiet_tx = ($urandom_range(0, 5) == 0);
            quiet_rx = ($urandom_range(0, 5) == 0);
            dmax = ($urandom_range(0, 3) == 0) ? 15 : 1023;
            if (pick < 70)
            begin
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, NMAX) : $urandom_range(1, 8);
                send_linked_chain(n, dmax);
            end
            else if (pick < 80)
            begin
                n = $urandom_range(NMAX + 1, NMAX + 4);
                for (int i = 0; i < n; i++)
                    send_matrix($urandom_range(0, dmax), $urandom_range(0, dmax), i == n - 1);
            end
            else
            begin
                n = $urandom_range(1, 10);
                for (int i = 0; i < n; i++)
                    send_matrix($urandom_range(0, 1023), $urandom_range(0, 1023), i == n - 1);
            end
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end
        quiet_tx = 1'b0;
        quiet_rx = 1'b0;
        wait_drained();
    endtask

    initial
    begin
        loaded = 0;
        dropped = 1'b0;
        leaf_no = 1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_lone_and_pair();
        test_ties_and_extremes();
        test_capacity();
        test_random_chains();
        repeat (50) @(posedge clk);
        $display("Ran %0d matrices in %0d chains (longest %0d), checked %0d tokens.",
                 items_sent, chains_done, longest_chain, tokens_seen);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0 && pending_tokens.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Timeout with %0d tokens still expected.", pending_tokens.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
